>>> hw/rtl/u8u16_pkg.sv
// Shared types and decode helpers for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
package u8u16_pkg;

	localparam int CP_W = 21;

	// One decoded byte's worth of work for the back end.
	typedef struct packed {
		logic [1:0]      npts;  // code points carried: 0, 1 or 2
		logic [CP_W-1:0] cp0;   // first code point, may need a surrogate pair
		logic [6:0]      cp1;   // second code point, always ASCII
		logic            fin;   // byte closed the string
	} job_t;

	localparam logic [15:0] HI_SURR = 16'hD800;
	localparam logic [15:0] LO_SURR = 16'hDC00;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	// Sequence length announced by a lead byte; zero for a byte that cannot lead.
	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] n;
		if (c[7] == 1'b0) n = 3'd1;
		else if ((c & 8'hE0) == 8'hC0) n = 3'd2;
		else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
		else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
		else n = 3'd0;
		return n;
	endfunction

	function automatic logic [CP_W-1:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] n);
		logic [CP_W-1:0] c;
		case (n)
			3'd2: c = {10'd0, b0[4:0], b1[5:0]};
			3'd3: c = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			3'd4: c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default: c = {14'd0, b0[6:0]};
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/u8u16_front.sv
// Front end: holds the pending UTF-8 sequence and turns each byte into a job.
`timescale 1ns / 1ps
module u8u16_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              is_final,
	output logic              job_push,
	output u8u16_pkg::job_t   job
);

	logic [7:0] held_q [0:2];
	logic [1:0] hc_q;
	logic [2:0] sl_q;

	logic       idle;
	logic       complete;
	logic [2:0] n_in;
	logic [2:0] n_h1;
	logic [7:0] buf1, buf2;
	logic       hold_lead;
	logic       store_cont;

	assign n_in = u8u16_pkg::lead_len(in_byte);
	assign n_h1 = u8u16_pkg::lead_len(held_q[1]);
	assign idle = (sl_q == 3'd0) || (hc_q == 2'd0);
	assign complete = ({1'b0, hc_q} + 3'd1) >= sl_q;
	assign buf1 = (hc_q == 2'd1) ? in_byte : held_q[1];
	assign buf2 = (hc_q == 2'd2) ? in_byte : held_q[2];

	always_comb begin
		job.npts = 2'd0;
		job.cp0 = '0;
		job.cp1 = '0;
		job.fin = is_final;
		hold_lead = 1'b0;
		store_cont = 1'b0;
		if (idle) begin
			if (n_in == 3'd1) begin
				job.npts = 2'd1;
				job.cp0 = {13'd0, in_byte};
			end else if (n_in >= 3'd2 && !is_final) begin
				hold_lead = 1'b1;
			end
		end else if (complete) begin
			job.npts = 2'd1;
			job.cp0 = u8u16_pkg::assemble(held_q[0], buf1, buf2, in_byte, sl_q);
		end else if (!is_final) begin
			store_cont = 1'b1;
		end else if (hc_q == 2'd1) begin
			// The string ended after a lone lead: only the final byte is decoded again.
			if (n_in == 3'd1) begin
				job.npts = 2'd1;
				job.cp0 = {14'd0, in_byte[6:0]};
			end
		end else begin
			// The lead is dropped; the held continuation and the final byte restart.
			if (n_h1 == 3'd1) begin
				job.cp0 = {14'd0, held_q[1][6:0]};
				if (n_in == 3'd1) begin
					job.npts = 2'd2;
					job.cp1 = in_byte[6:0];
				end else begin
					job.npts = 2'd1;
				end
			end else if (n_h1 == 3'd2) begin
				job.npts = 2'd1;
				job.cp0 = u8u16_pkg::assemble(held_q[1], in_byte, 8'd0, 8'd0, 3'd2);
			end else if (n_in == 3'd1) begin
				job.npts = 2'd1;
				job.cp0 = {14'd0, in_byte[6:0]};
			end
		end
	end

	assign job_push = accept && ((job.npts != 2'd0) || is_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= 2'd0;
			sl_q <= 3'd0;
		end else if (accept) begin
			if (hold_lead) begin
				hc_q <= 2'd1;
				sl_q <= n_in;
			end else if (store_cont) begin
				hc_q <= hc_q + 2'd1;
			end else begin
				hc_q <= 2'd0;
				sl_q <= 3'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_lead) begin
			held_q[0] <= in_byte;
		end
		if (accept && store_cont && hc_q == 2'd1) begin
			held_q[1] <= in_byte;
		end
		if (accept && store_cont && hc_q == 2'd2) begin
			held_q[2] <= in_byte;
		end
	end

endmodule

>>> hw/rtl/u8u16_fifo.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module u8u16_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  u8u16_pkg::job_t wr_data,
	input  logic            rd_en,
	output u8u16_pkg::job_t rd_data,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8u16_pkg::job_t mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> hw/rtl/u8u16_back.sv
// Back end: expands each job into UTF-16 results held in the output register.
`timescale 1ns / 1ps
module u8u16_back (
	input  logic            clk,
	input  logic            arst_n,
	input  u8u16_pkg::job_t job,
	input  logic            job_empty,
	output logic            job_pop,
	input  logic            pop,
	output logic            empty,
	output logic [15:0]     code_unit,
	output logic            unit_valid,
	output logic            string_end,
	output logic            run_last
);

	logic        out_valid_q;
	logic        phase_q;
	logic [15:0] code_unit_q;
	logic        unit_valid_q, string_end_q, run_last_q;

	logic                          load;
	logic                          big;
	logic [u8u16_pkg::CP_W-1:0]    v;
	logic [1:0]                    total;
	logic                          last;
	logic [15:0]                   unit;
	logic                          uvalid;

	assign load = !job_empty && (!out_valid_q || pop);
	assign big = (job.cp0[20:16] != 5'd0);
	assign v = job.cp0 - u8u16_pkg::SUPP_BASE;
	assign total = (job.npts == 2'd0) ? 2'd1 : job.npts + {1'b0, big};
	assign last = ({1'b0, phase_q} == (total - 2'd1));

	always_comb begin
		uvalid = 1'b1;
		if (!phase_q) begin
			if (job.npts == 2'd0) begin
				unit = 16'd0;
				uvalid = 1'b0;
			end else if (big) begin
				unit = u8u16_pkg::HI_SURR | {5'd0, v[20:10]};
			end else begin
				unit = job.cp0[15:0];
			end
		end else if (big) begin
			unit = u8u16_pkg::LO_SURR | {6'd0, v[9:0]};
		end else begin
			unit = {9'd0, job.cp1};
		end
	end

	assign job_pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q <= !last;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_unit_q <= unit;
			unit_valid_q <= uvalid;
			string_end_q <= job.fin && last;
			run_last_q <= last;
		end
	end

	assign empty = !out_valid_q;
	assign code_unit = code_unit_q;
	assign unit_valid = unit_valid_q;
	assign string_end = string_end_q;
	assign run_last = run_last_q;

endmodule

>>> hw/rtl/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
//   Channel   Handshake       Beat contents
//   input     push / full     in_byte, is_final
//   result    pop / empty     code_unit, unit_valid, string_end, run_last
//
// One byte is accepted per cycle while the job queue has room.
// Each byte yields zero, one or two results; the back end delivers one result
// per cycle while results are popped, so a surrogate pair leaves the output register as two results.
// Results are registered: a queued job reaches the result side through the output register.
// Reset clears the pending sequence, the queue and the output register.
// A stalled result side fills the queue, after which full holds off new bytes.
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder #(
	parameter int JOB_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        is_final,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] code_unit,
	output logic        unit_valid,
	output logic        string_end,
	output logic        run_last
);

	logic            accept;
	logic            job_push;
	logic            job_pop;
	logic            job_empty;
	u8u16_pkg::job_t new_job;
	u8u16_pkg::job_t head_job;

	assign accept = push && !full;

	u8u16_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.is_final (is_final),
		.job_push (job_push),
		.job      (new_job)
	);

	u8u16_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (new_job),
		.rd_en   (job_pop),
		.rd_data (head_job),
		.full    (full),
		.empty   (job_empty)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (head_job),
		.job_empty  (job_empty),
		.job_pop    (job_pop),
		.pop        (pop),
		.empty      (empty),
		.code_unit  (code_unit),
		.unit_valid (unit_valid),
		.string_end (string_end),
		.run_last   (run_last)
	);

endmodule

>>> bench/utf8_to_utf16_transcoder_tb.sv
// Self-checking bench for the UTF-8 to UTF-16 transcoder: random byte strings against a predictor.
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_tb;

	localparam int CALM_TAIL = 60;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_beat_t;

	typedef struct packed {
		logic [15:0] unit;
		logic        carries_unit;
		logic        string_end_mark;
		logic        byte_end_mark;
	} unit_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'h00;
	logic        is_final = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] code_unit;
	logic        unit_valid;
	logic        string_end;
	logic        run_last;

	byte_beat_t  pending_bytes[$];
	unit_beat_t  expected_units[$];
	logic [15:0] step_units[$];

	// Decoder state of the predictor.
	logic [7:0] held_seq [3] = '{8'h00, 8'h00, 8'h00};
	logic [1:0] held_n = 2'd0;
	logic [2:0] seq_len = 3'd0;

	int mismatches = 0;
	int drv_gap = 0;
	int drv_rate = 1;
	int drv_beats = 0;
	int mon_gap = 0;
	int mon_rate = 1;
	int mon_cycles = 0;
	byte_beat_t next_beat;

	utf8_to_utf16_transcoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.is_final(is_final),
		.empty(empty),
		.pop(pop),
		.code_unit(code_unit),
		.unit_valid(unit_valid),
		.string_end(string_end),
		.run_last(run_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int seq_bytes(input logic [7:0] c);
		casez (c)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default: return 0;
		endcase
	endfunction

	function automatic logic [20:0] code_point(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input int n);
		logic [31:0] v;
		case (n)
			2: v = (32'(b0 & 8'h1F) << 6) | 32'(b1 & 8'h3F);
			3: v = (32'(b0 & 8'h0F) << 12) | (32'(b1 & 8'h3F) << 6) | 32'(b2 & 8'h3F);
			4: v = (32'(b0 & 8'h07) << 18) | (32'(b1 & 8'h3F) << 12) |
				(32'(b2 & 8'h3F) << 6) | 32'(b3 & 8'h3F);
			default: v = 32'(b0 & 8'h7F);
		endcase
		return v[20:0];
	endfunction

	task automatic emit_point(input logic [20:0] cp);
		logic [31:0] v;
		if (cp > 21'h00FFFF) begin
			v = 32'(cp) - 32'h10000;
			step_units.insert(step_units.size(), 16'((v >> 10) | 32'hD800));
			step_units.insert(step_units.size(), 16'((v & 32'h3FF) | 32'hDC00));
		end else begin
			step_units.insert(step_units.size(), cp[15:0]);
		end
	endtask

	// Works out the units that one accepted byte causes and queues them.
	task automatic predict_units(input logic [7:0] b, input logic fin);
		logic [7:0] seq [4];
		logic [7:0] tail [5];
		unit_beat_t r;
		int n, m, i, j, hc, sl;
		step_units.delete();
		hc = int'(held_n);
		sl = int'(seq_len);
		if (sl == 0 || hc == 0) begin
			n = seq_bytes(b);
			held_n = 2'd0;
			seq_len = 3'd0;
			if (n == 1) begin
				step_units.insert(step_units.size(), {8'h00, b});
			end else if (n >= 2 && !fin) begin
				held_seq[0] = b;
				held_n = 2'd1;
				seq_len = 3'(n);
			end
		end else if (hc + 1 >= sl) begin
			seq[0] = held_seq[0];
			seq[1] = held_seq[1];
			seq[2] = held_seq[2];
			seq[3] = 8'h00;
			seq[hc] = b;
			emit_point(code_point(seq[0], seq[1], seq[2], seq[3], sl));
			held_n = 2'd0;
			seq_len = 3'd0;
		end else if (!fin) begin
			held_seq[hc] = b;
			held_n = 2'(hc + 1);
		end else begin
			// The string ended inside a sequence: drop its lead and decode the rest afresh.
			for (j = 0; j < 5; j++)
				tail[j] = 8'h00;
			m = 0;
			for (j = 1; j < hc; j++) begin
				tail[m] = held_seq[j];
				m++;
			end
			tail[m] = b;
			m++;
			i = 0;
			while (i < m) begin
				n = seq_bytes(tail[i]);
				if (n == 1) begin
					step_units.insert(step_units.size(), {8'h00, tail[i]});
					i++;
				end else if (n >= 2 && i + n <= m) begin
					emit_point(code_point(tail[i], tail[i+1], tail[i+2], tail[i+3], n));
					i += n;
				end else begin
					i++;
				end
			end
			held_n = 2'd0;
			seq_len = 3'd0;
		end
		if (step_units.size() > 0) begin
			for (j = 0; j < step_units.size(); j++) begin
				r.unit = step_units[j];
				r.carries_unit = 1'b1;
				r.byte_end_mark = (j == step_units.size() - 1);
				r.string_end_mark = fin && (j == step_units.size() - 1);
				expected_units.insert(expected_units.size(), r);
			end
		end else if (fin) begin
			r.unit = 16'h0000;
			r.carries_unit = 1'b0;
			r.string_end_mark = 1'b1;
			r.byte_end_mark = 1'b1;
			expected_units.insert(expected_units.size(), r);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic fin);
		byte_beat_t t;
		t.data = b;
		t.fin = fin;
		pending_bytes.insert(pending_bytes.size(), t);
	endtask

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return {2'b10, 6'($urandom)};
	endfunction

	// One random string; a cut string ends inside a sequence so that the tail is replayed.
	task automatic add_string(input int points, input bit cut);
		logic [7:0] s[$];
		int p, kind, len, extra, k;
		for (p = 0; p < points; p++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				s.insert(s.size(), {1'b0, 7'($urandom)});
			end else if (kind < 50) begin
				s.insert(s.size(), {3'b110, 5'($urandom)});
				s.insert(s.size(), cont_byte());
			end else if (kind < 68) begin
				s.insert(s.size(), {4'b1110, 4'($urandom)});
				s.insert(s.size(), cont_byte());
				s.insert(s.size(), cont_byte());
			end else if (kind < 86) begin
				s.insert(s.size(), {5'b11110, 3'($urandom)});
				s.insert(s.size(), cont_byte());
				s.insert(s.size(), cont_byte());
				s.insert(s.size(), cont_byte());
			end else begin
				s.insert(s.size(), 8'($urandom_range(0, 255)));
			end
		end
		if (cut) begin
			len = $urandom_range(2, 4);
			case (len)
				2: s.insert(s.size(), {3'b110, 5'($urandom)});
				3: s.insert(s.size(), {4'b1110, 4'($urandom)});
				default: s.insert(s.size(), {5'b11110, 3'($urandom)});
			endcase
			extra = $urandom_range(0, len - 2);
			for (k = 0; k < extra; k++) begin
				case ($urandom_range(0, 2))
					0: s.insert(s.size(), {1'b0, 7'($urandom)});
					1: s.insert(s.size(), {3'b110, 5'($urandom)});
					default: s.insert(s.size(), {2'b10, 6'($urandom)});
				endcase
			end
		end
		for (k = 0; k < s.size(); k++)
			add_byte(s[k], k == s.size() - 1);
	endtask

	// Input side: a new beat is presented once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				predict_units(in_byte, is_final);
			if (!push || !full) begin
				if (drv_gap > 0) begin
					drv_gap--;
					push <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					next_beat = pending_bytes.pop_front();
					push <= 1'b1;
					in_byte <= next_beat.data;
					is_final <= next_beat.fin;
					drv_beats++;
					if (drv_beats % 64 == 0)
						drv_rate = $urandom_range(0, 3);
					if (pending_bytes.size() > CALM_TAIL && drv_rate != 0 &&
						$urandom_range(0, 7) < drv_rate)
						drv_gap = $urandom_range(1, 14);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result side: each accepted beat is checked against the oldest expected unit.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_units.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: unit %h valid %b end %b last %b",
							code_unit, unit_valid, string_end, run_last);
				end else begin
					if (code_unit !== expected_units[0].unit ||
						unit_valid !== expected_units[0].carries_unit ||
						string_end !== expected_units[0].string_end_mark ||
						run_last !== expected_units[0].byte_end_mark) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
								expected_units[0].unit, expected_units[0].carries_unit,
								expected_units[0].string_end_mark,
								expected_units[0].byte_end_mark,
								code_unit, unit_valid, string_end, run_last);
					end
					void'(expected_units.pop_front());
				end
			end
			mon_cycles++;
			if (mon_cycles % 100 == 0)
				mon_rate = $urandom_range(0, 3);
			if (mon_gap > 0) begin
				mon_gap--;
				pop <= 1'b0;
			end else if (pending_bytes.size() > CALM_TAIL && mon_rate != 0 &&
				$urandom_range(0, 11) < mon_rate) begin
				mon_gap = $urandom_range(0, 13);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		// ASCII extremes, every sequence length, a four-byte value below 0x10000,
		// one above 0x10FFFF, an invalid lead and a lead that closes the string.
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'hC2, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hEF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hF0, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hF7, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hC3, 1'b1);
		// An invalid byte alone as the string leaves only the end mark.
		add_byte(8'h80, 1'b1);
		// Unfinished four-byte sequence whose tail is a complete two-byte one.
		add_byte(8'hF0, 1'b0);
		add_byte(8'hC3, 1'b0);
		add_byte(8'hA9, 1'b1);
		// Unfinished three-byte sequence ended by ASCII.
		add_byte(8'hE2, 1'b0);
		add_byte(8'h41, 1'b1);
		// A sequence completed by the final byte.
		add_byte(8'hF0, 1'b0);
		add_byte(8'h90, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b1);
		while (pending_bytes.size() < 460)
			add_string($urandom_range(1, 8), $urandom_range(0, 3) == 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_bytes.size() != 0 || push)
			@(posedge clk);
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_units.size() == 0)
			$display("utf8_to_utf16_transcoder_tb passed");
		else
			$display("utf8_to_utf16_transcoder_tb failed");
		$finish;
	end

	initial begin
		#1000000;
		$display("utf8_to_utf16_transcoder_tb failed");
		$finish;
	end

endmodule
